FILE: rtl/core/spk_pkg.sv
// ----------------------------------------------------------------------------
// spk_pkg
// Shared types, constants and word functions for the Speck encryption block.
// ----------------------------------------------------------------------------
package spk_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned IDX_W  = 6;
	localparam int unsigned CFG_W  = 3;
	localparam int unsigned VAR_W  = 4;

	// configuration register indexes
	localparam logic [CFG_W-1:0] REG_VARIANT = 3'd0;
	localparam logic [CFG_W-1:0] REG_KEY0    = 3'd1;
	localparam logic [CFG_W-1:0] REG_KEY1    = 3'd2;
	localparam logic [CFG_W-1:0] REG_KEY2    = 3'd3;
	localparam logic [CFG_W-1:0] REG_KEY3    = 3'd4;

	localparam logic [VAR_W-1:0] VARIANT_RST = 4'd4;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [2:0] {
		W16,
		W24,
		W32,
		W48,
		W64
	} wsize_t;

	typedef struct packed {
		wsize_t           ws;
		logic [2:0]       m;     // key words
		logic [IDX_W-1:0] last;  // round count minus one
	} shape_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic done;
	} ctrl_t;

	function automatic shape_t shape_of(input logic [VAR_W-1:0] v);
		shape_t s;
		case (v)
			4'd0:    s = '{ws: W16, m: 3'd4, last: 6'd21};
			4'd1:    s = '{ws: W24, m: 3'd3, last: 6'd21};
			4'd2:    s = '{ws: W24, m: 3'd4, last: 6'd22};
			4'd3:    s = '{ws: W32, m: 3'd3, last: 6'd25};
			4'd4:    s = '{ws: W32, m: 3'd4, last: 6'd26};
			4'd5:    s = '{ws: W48, m: 3'd2, last: 6'd27};
			4'd6:    s = '{ws: W48, m: 3'd3, last: 6'd28};
			4'd7:    s = '{ws: W64, m: 3'd2, last: 6'd31};
			4'd8:    s = '{ws: W64, m: 3'd3, last: 6'd32};
			default: s = '{ws: W64, m: 3'd4, last: 6'd33};
		endcase
		return s;
	endfunction

	function automatic word_t word_mask(input wsize_t ws);
		word_t r;
		case (ws)
			W16:     r = {48'd0, {16{1'b1}}};
			W24:     r = {40'd0, {24{1'b1}}};
			W32:     r = {32'd0, {32{1'b1}}};
			W48:     r = {16'd0, {48{1'b1}}};
			default: r = {64{1'b1}};
		endcase
		return r;
	endfunction

	// rotate right by alpha (7 for 16-bit words, 8 otherwise)
	function automatic word_t ror_a(input word_t v, input wsize_t ws);
		word_t r;
		case (ws)
			W16:     r = {48'd0, v[6:0], v[15:7]};
			W24:     r = {40'd0, v[7:0], v[23:8]};
			W32:     r = {32'd0, v[7:0], v[31:8]};
			W48:     r = {16'd0, v[7:0], v[47:8]};
			default: r = {v[7:0], v[63:8]};
		endcase
		return r;
	endfunction

	// rotate left by beta (2 for 16-bit words, 3 otherwise)
	function automatic word_t rol_b(input word_t v, input wsize_t ws);
		word_t r;
		case (ws)
			W16:     r = {48'd0, v[13:0], v[15:14]};
			W24:     r = {40'd0, v[20:0], v[23:21]};
			W32:     r = {32'd0, v[28:0], v[31:29]};
			W48:     r = {16'd0, v[44:0], v[47:45]};
			default: r = {v[60:0], v[63:61]};
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/spk_round.sv
// ----------------------------------------------------------------------------
// spk_round
// One Speck round: x' = (ror(x) + y) ^ k, y' = rol(y) ^ x', at word size ws.
// ----------------------------------------------------------------------------
module spk_round (
	input  spk_pkg::word_t  x,
	input  spk_pkg::word_t  y,
	input  spk_pkg::word_t  k,
	input  spk_pkg::wsize_t ws,
	output spk_pkg::word_t  x_nxt,
	output spk_pkg::word_t  y_nxt
);
	import spk_pkg::*;

	word_t sum;

	// inputs are already masked, so only the sum needs trimming
	assign sum   = (ror_a(x, ws) + y) & word_mask(ws);
	assign x_nxt = sum ^ k;
	assign y_nxt = rol_b(y, ws) ^ x_nxt;

endmodule

FILE: rtl/core/spk_ctrl.sv
// ----------------------------------------------------------------------------
// spk_ctrl
// Round sequencer: takes an item, counts rounds, hands off the result.
// ----------------------------------------------------------------------------
module spk_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      slot_free,
	input  logic [spk_pkg::IDX_W-1:0] last,
	output logic                      idle,
	output logic [spk_pkg::IDX_W-1:0] round_idx,
	output spk_pkg::ctrl_t            ctrl
);
	import spk_pkg::*;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	logic             at_last;

	assign at_last   = (idx_q == last);
	assign round_idx = idx_q;
	assign idle      = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ctrl.load) begin
				idx_q <= '0;
			end else if (ctrl.step) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctrl.load = 1'b1;
					state_d   = ST_RUN;
				end
			end
			ST_RUN: begin
				// final round waits until the output register can take it
				if (!at_last) begin
					ctrl.step = 1'b1;
				end else if (slot_free) begin
					ctrl.step = 1'b1;
					ctrl.done = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/core/speck_block_encrypt.sv
// ----------------------------------------------------------------------------
// speck_block_encrypt
// Speck block encryption over all ten standard block/key sizes.
// ----------------------------------------------------------------------------
// usage
//   config: cfg_we writes cfg_data to register cfg_index (0 variant, 1..4 key
//   words); write only while the block is idle. unknown indexes are ignored
//   input: plain_left / plain_right transfer on in_valid && in_ready; bits
//   above the selected word size are dropped
//   output: cipher_left / cipher_right transfer on out_valid && out_ready
//   rounds: the round count of the variant is 22 to 34; one round per cycle,
//   set by the single round datapath with the key schedule stepped alongside
//   it, while the last round can hold for a full output register; out_valid
//   rises with the last round; in_ready is low while rounds run
//   the output register frees the input side: a new item is taken while the
//   previous result waits; if the receiver stalls past the end of the next
//   item, the last round holds until the output register is free
//   reset: arst_n clears the sequencer and the output valid at once, sets the
//   variant to 64/128 and the key words to zero
// ----------------------------------------------------------------------------
module speck_block_encrypt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [spk_pkg::CFG_W-1:0] cfg_index,
	input  spk_pkg::word_t            cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  spk_pkg::word_t            plain_left,
	input  spk_pkg::word_t            plain_right,
	output logic                      out_valid,
	input  logic                      out_ready,
	output spk_pkg::word_t            cipher_left,
	output spk_pkg::word_t            cipher_right
);
	import spk_pkg::*;

	// configuration registers
	logic [VAR_W-1:0] variant_q;
	word_t            key_q [4];

	// working state of the current block
	shape_t           shape_q;
	shape_t           shape_new;
	word_t            x_q, y_q, k_q;
	word_t            l_q [3];
	word_t            mask_new;

	// result register
	logic             out_valid_q;
	word_t            cl_q, cr_q;

	ctrl_t            ctrl;
	logic             idle;
	logic             slot_free;
	logic [IDX_W-1:0] round_idx;
	word_t            x_nxt, y_nxt, l_nxt, k_nxt;

	assign shape_new = shape_of(variant_q);
	assign mask_new  = word_mask(shape_new.ws);
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= VARIANT_RST;
			key_q[0]  <= '0;
			key_q[1]  <= '0;
			key_q[2]  <= '0;
			key_q[3]  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VARIANT: variant_q <= cfg_data[VAR_W-1:0];
				REG_KEY0:    key_q[0]  <= cfg_data;
				REG_KEY1:    key_q[1]  <= cfg_data;
				REG_KEY2:    key_q[2]  <= cfg_data;
				REG_KEY3:    key_q[3]  <= cfg_data;
				default:     ;
			endcase
		end
	end

	spk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.slot_free (slot_free),
		.last      (shape_q.last),
		.idle      (idle),
		.round_idx (round_idx),
		.ctrl      (ctrl)
	);

	// data round with the current round key
	spk_round u_data_round (
		.x     (x_q),
		.y     (y_q),
		.k     (k_q),
		.ws    (shape_q.ws),
		.x_nxt (x_nxt),
		.y_nxt (y_nxt)
	);

	// key schedule step: same round with l as x, k as y and the index as key
	spk_round u_key_round (
		.x     (l_q[0]),
		.y     (k_q),
		.k     ({{(WORD_W-IDX_W){1'b0}}, round_idx}),
		.ws    (shape_q.ws),
		.x_nxt (l_nxt),
		.y_nxt (k_nxt)
	);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			shape_q <= shape_new;
			x_q     <= plain_left & mask_new;
			y_q     <= plain_right & mask_new;
			k_q     <= key_q[0] & mask_new;
			l_q[0]  <= key_q[1] & mask_new;
			l_q[1]  <= key_q[2] & mask_new;
			l_q[2]  <= key_q[3] & mask_new;
		end else if (ctrl.step) begin
			x_q <= x_nxt;
			y_q <= y_nxt;
			k_q <= k_nxt;
			// the new l word goes to the tail of an (m-1)-deep queue
			case (shape_q.m)
				3'd2: begin
					l_q[0] <= l_nxt;
				end
				3'd3: begin
					l_q[0] <= l_q[1];
					l_q[1] <= l_nxt;
				end
				default: begin
					l_q[0] <= l_q[1];
					l_q[1] <= l_q[2];
					l_q[2] <= l_nxt;
				end
			endcase
		end
		if (ctrl.done) begin
			cl_q <= x_nxt;
			cr_q <= y_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready     = idle;
	assign out_valid    = out_valid_q;
	assign cipher_left  = cl_q;
	assign cipher_right = cr_q;

endmodule

FILE: rtl/core/spk_checker.sv
// ----------------------------------------------------------------------------
// spk_checker
// Port-level checks for the Speck encryption block, bound to the top level.
// ----------------------------------------------------------------------------
module spk_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input spk_pkg::word_t cipher_left,
	input spk_pkg::word_t cipher_right
);

	// a block is busy for its rounds right after the input transfer
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready high right after an input transfer");

	// a new result only ever appears at the end of a run
	a_result_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a run in progress");

	// a finished run leaves the sequencer idle
	a_idle_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("sequencer not idle after a result");

	// a stalled result stays put
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cipher_left)
			&& $stable(cipher_right))
		else $error("stalled result dropped or changed");

endmodule

bind speck_block_encrypt spk_checker u_spk_checker (.*);

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Speck block encryption core. A short table of
// directed blocks and register writes walks every size, the saturating variant
// values, wide keys and wide plaintext; random segments follow, each under
// a fresh key and variant, with long output holds and, bar the last three,
// random gaps and stalls. Each result transfer is checked against a local cipher model.
// ----------------------------------------------------------------------------
module tb_top;
	import spk_pkg::*;

	localparam int WATCHDOG  = 4000;
	localparam int HOLD_LEN  = 200;
	localparam int HOLD_STEP = 300;
	localparam int TAIL      = 40;
	localparam int SEG_ITEMS = 100;
	localparam int SEGMENTS  = 9;

	localparam word_t ALL_ONES = {WORD_W{1'b1}};

	// variant codes
	localparam logic [VAR_W-1:0] V32_64     = 4'd0;
	localparam logic [VAR_W-1:0] V48_72     = 4'd1;
	localparam logic [VAR_W-1:0] V48_96     = 4'd2;
	localparam logic [VAR_W-1:0] V64_96     = 4'd3;
	localparam logic [VAR_W-1:0] V64_128    = 4'd4;
	localparam logic [VAR_W-1:0] V96_96     = 4'd5;
	localparam logic [VAR_W-1:0] V96_144    = 4'd6;
	localparam logic [VAR_W-1:0] V128_128   = 4'd7;
	localparam logic [VAR_W-1:0] V128_192   = 4'd8;
	localparam logic [VAR_W-1:0] V128_256   = 4'd9;
	localparam logic [VAR_W-1:0] VAR_SAT_LO = 4'd10;
	localparam logic [VAR_W-1:0] VAR_SAT_HI = 4'd15;

	// register indexes with no register behind them
	localparam logic [CFG_W-1:0] REG_UNUSED_LO = 3'd5;
	localparam logic [CFG_W-1:0] REG_UNUSED_HI = 3'd7;

	typedef logic [3:0][WORD_W-1:0] key_set_t;

	typedef struct packed {
		word_t left;
		word_t right;
	} cipher_t;

	typedef enum logic {
		ROW_WRITE,
		ROW_BLOCK
	} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		logic [CFG_W-1:0] idx;
		word_t            data;
		word_t            left;
		word_t            right;
	} step_row_t;

	function automatic step_row_t wr(input logic [CFG_W-1:0] idx, input word_t data);
		return '{ROW_WRITE, idx, data, '0, '0};
	endfunction

	function automatic step_row_t blk(input word_t left, input word_t right);
		return '{ROW_BLOCK, '0, '0, left, right};
	endfunction

	// directed stimulus, walked in order; every block is checked by the model
	localparam int DIR_ROWS = 42;
	localparam step_row_t DIRECTED [DIR_ROWS] = '{
		// reset settings: 64/128 with an all-zero key
		blk(64'h0, 64'h0),
		blk(ALL_ONES, ALL_ONES),
		// 32/64 with the published key and plaintext
		wr(REG_KEY0, 64'h0100),
		wr(REG_KEY1, 64'h0908),
		wr(REG_KEY2, 64'h1110),
		wr(REG_KEY3, 64'h1918),
		wr(REG_VARIANT, 64'(V32_64)),
		blk(64'h6574, 64'h694c),
		// same block with junk above the word size
		blk(64'hffff_ffff_ffff_6574, 64'hffff_ffff_ffff_694c),
		// key words wider than the selected word size
		wr(REG_KEY0, ALL_ONES),
		wr(REG_KEY1, ALL_ONES),
		wr(REG_KEY2, ALL_ONES),
		wr(REG_KEY3, ALL_ONES),
		blk(ALL_ONES, ALL_ONES),
		blk(64'h0, 64'h0),
		// walk every size
		wr(REG_VARIANT, 64'(V48_72)),
		blk(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210),
		wr(REG_VARIANT, 64'(V48_96)),
		blk(64'h8000_0000_0080_0000, 64'h0000_0000_0000_0001),
		wr(REG_VARIANT, 64'(V64_96)),
		blk(64'h5555_5555_aaaa_aaaa, 64'haaaa_aaaa_5555_5555),
		wr(REG_VARIANT, 64'(V64_128)),
		blk(64'h0000_0000_8000_0000, 64'hffff_ffff_7fff_ffff),
		wr(REG_VARIANT, 64'(V96_96)),
		blk(64'h0000_8000_0000_0000, 64'h0000_7fff_ffff_ffff),
		wr(REG_VARIANT, 64'(V96_144)),
		blk(64'hdead_beef_cafe_f00d, 64'h0f0f_0f0f_f0f0_f0f0),
		wr(REG_VARIANT, 64'(V128_128)),
		blk(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001),
		wr(REG_VARIANT, 64'(V128_192)),
		blk(64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000),
		wr(REG_VARIANT, 64'(V128_256)),
		blk(ALL_ONES, 64'h0),
		// out-of-range variants act as the largest size
		wr(REG_VARIANT, 64'(VAR_SAT_LO)),
		blk(64'h0123_4567_89ab_cdef, 64'h0123_4567_89ab_cdef),
		wr(REG_VARIANT, 64'(VAR_SAT_HI)),
		blk(ALL_ONES, ALL_ONES),
		// writes to unused indexes must change nothing
		wr(REG_UNUSED_LO, 64'h0),
		wr(REG_UNUSED_HI, 64'h0),
		blk(ALL_ONES, 64'h0),
		// variant data above the low nibble is dropped
		wr(REG_VARIANT, 64'hffff_ffff_ffff_fff0),
		blk(64'h8000, 64'h0001)
	};

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_we       = 1'b0;
	logic [CFG_W-1:0]     cfg_index    = '0;
	word_t                cfg_data     = '0;
	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	word_t                plain_left   = '0;
	word_t                plain_right  = '0;
	logic                 out_valid;
	logic                 out_ready    = 1'b0;
	word_t                cipher_left;
	word_t                cipher_right;

	// settings the core holds, as written by this bench
	logic [VAR_W-1:0]     cur_variant  = VARIANT_RST;
	key_set_t             cur_key      = '0;

	cipher_t              pending_cipher [$];
	cipher_t              want_blk;
	int                   blocks_in    = 0;   // input transfers, seen at the edge
	int                   blocks_out   = 0;   // output transfers, seen at the edge
	int                   blocks_sent  = 0;   // input transfers, counted by the sender
	int                   bad_count    = 0;
	int                   quiet        = 0;
	int                   hold_left    = 0;
	int                   next_hold    = 150;
	int                   send_idle    = 29;
	int                   recv_idle    = 47;

	speck_block_encrypt dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.plain_left   (plain_left),
		.plain_right  (plain_right),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cipher_left  (cipher_left),
		.cipher_right (cipher_right)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// cipher model
	// ------------------------------------------------------------------
	function automatic word_t lane_mask(input int unsigned n);
		return ALL_ONES >> (WORD_W - n);
	endfunction

	// rotate left by r within an n-bit word
	function automatic word_t rotl_n(input word_t v, input int unsigned r, input int unsigned n);
		word_t w;
		w = v & lane_mask(n);
		return ((w << r) | (w >> (n - r))) & lane_mask(n);
	endfunction

	// full encryption with the key schedule stepped alongside the rounds
	function automatic cipher_t speck_encrypt(input logic [VAR_W-1:0] sel,
			input key_set_t keys, input word_t pl, input word_t pr);
		logic [VAR_W-1:0] vs;
		int unsigned      n, m, rounds, ra, rb, i;
		word_t            msk, x, y, kr, nl;
		word_t            lw [40];
		cipher_t          res;
		vs = (sel > V128_256) ? V128_256 : sel;
		case (vs)
			V32_64:   begin n = 16; m = 4; rounds = 22; end
			V48_72:   begin n = 24; m = 3; rounds = 22; end
			V48_96:   begin n = 24; m = 4; rounds = 23; end
			V64_96:   begin n = 32; m = 3; rounds = 26; end
			V64_128:  begin n = 32; m = 4; rounds = 27; end
			V96_96:   begin n = 48; m = 2; rounds = 28; end
			V96_144:  begin n = 48; m = 3; rounds = 29; end
			V128_128: begin n = 64; m = 2; rounds = 32; end
			V128_192: begin n = 64; m = 3; rounds = 33; end
			default:  begin n = 64; m = 4; rounds = 34; end
		endcase
		ra  = (n == 16) ? 7 : 8;
		rb  = (n == 16) ? 2 : 3;
		msk = lane_mask(n);
		kr  = keys[0] & msk;
		for (i = 0; i + 1 < m; i++)
			lw[i] = keys[i + 1] & msk;
		x = pl & msk;
		y = pr & msk;
		for (i = 0; i < rounds; i++) begin
			x = ((rotl_n(x, n - ra, n) + y) & msk) ^ kr;
			y = rotl_n(y, rb, n) ^ x;
			// next round key
			if (i + 1 < rounds) begin
				nl = ((kr + rotl_n(lw[i], n - ra, n)) & msk) ^ word_t'(i);
				lw[i + m - 1] = nl;
				kr = rotl_n(kr, rb, n) ^ nl;
			end
		end
		res.left  = x;
		res.right = y;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// result checking and input bookkeeping
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		// check first so a result never pairs with the block taken at this edge
		if (out_valid && out_ready) begin
			blocks_out <= blocks_out + 1;
			if (pending_cipher.size() == 0) begin
				if (bad_count < 10)
					$display("unexpected result transfer: got %h %h",
						cipher_left, cipher_right);
				bad_count++;
			end else begin
				want_blk = pending_cipher.pop_front();
				if (want_blk.left !== cipher_left || want_blk.right !== cipher_right) begin
					if (bad_count < 10)
						$display("cipher mismatch: want %h %h got %h %h",
							want_blk.left, want_blk.right, cipher_left, cipher_right);
					bad_count++;
				end
			end
		end
		if (in_valid && in_ready) begin
			pending_cipher.push_back(speck_encrypt(cur_variant, cur_key,
				plain_left, plain_right));
			blocks_in <= blocks_in + 1;
		end
	end

	// ------------------------------------------------------------------
	// receiver: random stalls, plus a long hold every few hundred blocks so
	// the core fills up and has to drop in_ready
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (blocks_in == next_hold) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_LEN;
			next_hold <= next_hold + HOLD_STEP;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// ------------------------------------------------------------------
	// watchdog: too long without any transfer ends the run
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// sender side
	// ------------------------------------------------------------------

	// offer one block, with random gaps before it; returns at its transfer
	task automatic offer_block(input word_t left, input word_t right);
		cfg_we <= 1'b0;
		while ($urandom_range(99) < send_idle) begin
			in_valid    <= 1'b0;
			plain_left  <= {$urandom, $urandom};
			plain_right <= {$urandom, $urandom};
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		plain_left  <= left;
		plain_right <= right;
		do
			@(posedge clk);
		while (!in_ready);
		blocks_sent++;
	endtask

	// stop offering and wait until every block has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (blocks_out != blocks_sent)
			@(posedge clk);
	endtask

	// one register write; cfg_we is dropped by the next block offer
	task automatic write_reg(input logic [CFG_W-1:0] idx, input word_t val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_VARIANT: cur_variant = val[VAR_W-1:0];
			REG_KEY0:    cur_key[0]  = val;
			REG_KEY1:    cur_key[1]  = val;
			REG_KEY2:    cur_key[2]  = val;
			REG_KEY3:    cur_key[3]  = val;
			default:     ;
		endcase
	endtask

	// fresh variant and key, then a run of random blocks
	task automatic run_segment(input int seg);
		logic [VAR_W-1:0] vsel;
		word_t            kv, vd, pl, pr;
		int               w, n;
		drain();
		case (seg)
			0:       vsel = V32_64;
			4:       vsel = VAR_SAT_HI;
			8:       vsel = V128_256;
			default: vsel = VAR_W'($urandom_range(15));
		endcase
		vd = {$urandom, $urandom};
		vd[VAR_W-1:0] = vsel;
		write_reg(REG_VARIANT, vd);
		for (w = 0; w < 4; w++) begin
			case ($urandom_range(3))
				0:       kv = '0;
				1:       kv = ALL_ONES;
				default: kv = {$urandom, $urandom};
			endcase
			write_reg(CFG_W'(REG_KEY0 + w), kv);
		end
		if ($urandom_range(1))
			write_reg(CFG_W'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)),
				{$urandom, $urandom});
		for (n = 0; n < SEG_ITEMS; n++) begin
			case ($urandom_range(9))
				0:       begin pl = '0;       pr = '0;       end
				1:       begin pl = ALL_ONES; pr = ALL_ONES; end
				default: begin pl = {$urandom, $urandom}; pr = {$urandom, $urandom}; end
			endcase
			offer_block(pl, pr);
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int r = 0; r < DIR_ROWS; r++) begin
			if (DIRECTED[r].kind == ROW_WRITE) begin
				drain();
				write_reg(DIRECTED[r].idx, DIRECTED[r].data);
			end else begin
				offer_block(DIRECTED[r].left, DIRECTED[r].right);
			end
		end

		// random segments: sender-light, receiver-light, then no idling
		for (int s = 0; s < SEGMENTS; s++) begin
			if (s == 3) begin
				send_idle = 47;
				recv_idle = 29;
			end else if (s == 6) begin
				send_idle = 0;
				recv_idle = 0;
			end
			run_segment(s);
		end

		drain();
		repeat (TAIL) @(posedge clk);
		if (pending_cipher.size() != 0) begin
			if (bad_count < 10)
				$display("%0d blocks never came back", pending_cipher.size());
			bad_count++;
		end
		if (bad_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: speck_block_encrypt.f
rtl/core/spk_pkg.sv
rtl/core/spk_round.sv
rtl/core/spk_ctrl.sv
rtl/core/speck_block_encrypt.sv
rtl/core/spk_checker.sv
bench/tb_top.sv
